>>> design/mrg_pkg.sv
// ----------------------------------------------------------------------------
// mrg_pkg
// Shared types and constants of the MRG32k5a random generator: moduli,
// operation codes, queue entry, step operands and step results.
// ----------------------------------------------------------------------------
package mrg_pkg;

    localparam int WORD_W      = 32;
    localparam int HIST_DEPTH  = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WORD_W-1:0] M1        = 32'd4294949027;
    localparam logic [WORD_W-1:0] M2        = 32'd4294934327;
    localparam logic [WORD_W-1:0] INIT_WORD = 32'd12345;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_GENERATE = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_ABSORB   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_LAUNCH,
        ST_STEP
    } back_state_t;

    typedef struct packed {
        op_t   op;
        word_t seed_word;
    } cmd_t;

    // operands of one step of both recurrences
    typedef struct packed {
        word_t w13;
        word_t w11;
        word_t w10;
        word_t w24;
        word_t w22;
        word_t w20;
    } step_words_t;

    typedef struct packed {
        word_t x1;
        word_t x2;
    } step_result_t;

endpackage

>>> design/mrg_if.sv
// ----------------------------------------------------------------------------
// mrg_cmd_if / mrg_value_if
// Valid/ready channels of the generator: commands in, random values out.
// ----------------------------------------------------------------------------
interface mrg_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [mrg_pkg::WORD_W-1:0] seed_word;

    modport source (output valid, output op, output seed_word, input ready);
    modport sink   (input valid, input op, input seed_word, output ready);
endinterface

interface mrg_value_if;
    logic                       valid;
    logic                       ready;
    logic [mrg_pkg::WORD_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

>>> design/mrg_front.sv
// ----------------------------------------------------------------------------
// mrg_front
// Accepts commands, drops the unused op code and queues the rest for the
// back end in a small FIFO.
// ----------------------------------------------------------------------------
module mrg_front (
    input  logic          clk,
    input  logic          rst_n,
    mrg_cmd_if.sink       cmd,
    output logic          q_valid,
    output mrg_pkg::cmd_t q_cmd,
    input  logic          q_pop
);

    localparam int PTR_W = $clog2(mrg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mrg_pkg::QUEUE_DEPTH + 1);

    mrg_pkg::cmd_t    slot_reg [mrg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             keep;
    logic             push;
    mrg_pkg::cmd_t    entry;

    always_comb
    begin
        case (mrg_pkg::op_t'(cmd.op))
            mrg_pkg::OP_GENERATE,
            mrg_pkg::OP_CLEAR,
            mrg_pkg::OP_ABSORB: keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    assign cmd.ready       = (count_reg != CNT_W'(mrg_pkg::QUEUE_DEPTH));
    assign push            = cmd.valid && cmd.ready && keep;
    assign entry.op        = mrg_pkg::op_t'(cmd.op);
    assign entry.seed_word = cmd.seed_word;

    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mrg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mrg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

>>> design/mrg_step_pipe.sv
// ----------------------------------------------------------------------------
// mrg_step_pipe
// Four-stage datapath for one step of both recurrences: multiply, sum,
// fold the high part by 2^32 mod m, then a second fold and final subtract.
// ----------------------------------------------------------------------------
module mrg_step_pipe (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  launch,
    input  mrg_pkg::step_words_t  words,
    output logic                  done,
    output mrg_pkg::step_result_t result
);

    localparam logic [20:0] A12  = 21'd1154721;
    localparam logic [20:0] A14  = 21'd1739991;
    localparam logic [20:0] A15N = 21'd1108499;
    localparam logic [20:0] A21  = 21'd1776413;
    localparam logic [20:0] A23  = 21'd865203;
    localparam logic [20:0] A25N = 21'd1641052;

    // 2^32 mod m for each modulus
    localparam logic [14:0] C1 = 15'd18269;
    localparam logic [15:0] C2 = 16'd32969;

    // offsets that keep the sums non-negative
    localparam logic [54:0] K1 = 55'(2) * 55'(A15N) * 55'(mrg_pkg::M1);
    localparam logic [54:0] K2 = 55'(2) * 55'(A25N) * 55'(mrg_pkg::M2);

    logic [3:0]  vld_reg;

    logic [52:0] p1a_reg;
    logic [52:0] p1b_reg;
    logic [52:0] p1c_reg;
    logic [52:0] p2a_reg;
    logic [52:0] p2b_reg;
    logic [52:0] p2c_reg;
    logic [54:0] t1_reg;
    logic [54:0] t2_reg;
    logic [38:0] f1_reg;
    logic [39:0] f2_reg;
    mrg_pkg::step_result_t res_reg;

    logic [32:0] g1;
    logic [32:0] g2;
    logic [33:0] d1;
    logic [33:0] d2;
    mrg_pkg::step_result_t res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], launch};
        end
    end

    always_ff @(posedge clk)
    begin
        p1a_reg <= 53'(A12) * 53'(words.w13);
        p1b_reg <= 53'(A14) * 53'(words.w11);
        p1c_reg <= 53'(A15N) * 53'(words.w10);
        p2a_reg <= 53'(A21) * 53'(words.w24);
        p2b_reg <= 53'(A23) * 53'(words.w22);
        p2c_reg <= 53'(A25N) * 53'(words.w20);

        t1_reg <= 55'(p1a_reg) + 55'(p1b_reg) + K1 - 55'(p1c_reg);
        t2_reg <= 55'(p2a_reg) + 55'(p2b_reg) + K2 - 55'(p2c_reg);

        f1_reg <= 39'(t1_reg[31:0]) + 39'(t1_reg[54:32]) * 39'(C1);
        f2_reg <= 40'(t2_reg[31:0]) + 40'(t2_reg[54:32]) * 40'(C2);

        res_reg <= res_next;
    end

    // second fold leaves a value below 2m, one subtract finishes it
    always_comb
    begin
        g1 = 33'(f1_reg[31:0]) + 33'(f1_reg[38:32]) * 33'(C1);
        g2 = 33'(f2_reg[31:0]) + 33'(f2_reg[39:32]) * 33'(C2);
        d1 = {1'b0, g1} - 34'(mrg_pkg::M1);
        d2 = {1'b0, g2} - 34'(mrg_pkg::M2);
        res_next.x1 = d1[33] ? g1[31:0] : d1[31:0];
        res_next.x2 = d2[33] ? g2[31:0] : d2[31:0];
    end

    assign done   = vld_reg[3];
    assign result = res_reg;

endmodule

>>> design/mrg_back.sv
// ----------------------------------------------------------------------------
// mrg_back
// Back end: sequences generate, clear and absorb over the step pipeline,
// keeps both five-word histories and holds results in an output register
// with a skid stage.
// ----------------------------------------------------------------------------
module mrg_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  mrg_pkg::cmd_t q_cmd,
    output logic          q_pop,
    mrg_value_if.source   result
);

    localparam int ABSORB_STEPS = 5;
    localparam int STEP_W       = $clog2(ABSORB_STEPS + 1);

    mrg_pkg::back_state_t state_reg;
    mrg_pkg::back_state_t state_next;
    mrg_pkg::op_t         op_reg;
    mrg_pkg::op_t         op_next;
    mrg_pkg::word_t       seed_reg;
    mrg_pkg::word_t       seed_next;
    logic                 half_reg;
    logic                 half_next;
    logic [STEP_W-1:0]    steps_reg;
    logic [STEP_W-1:0]    steps_next;

    mrg_pkg::word_t h1_reg  [mrg_pkg::HIST_DEPTH];
    mrg_pkg::word_t h2_reg  [mrg_pkg::HIST_DEPTH];
    mrg_pkg::word_t h1_next [mrg_pkg::HIST_DEPTH];
    mrg_pkg::word_t h2_next [mrg_pkg::HIST_DEPTH];
    mrg_pkg::word_t h1_sh   [mrg_pkg::HIST_DEPTH];
    mrg_pkg::word_t h2_sh   [mrg_pkg::HIST_DEPTH];
    mrg_pkg::word_t h1_src  [mrg_pkg::HIST_DEPTH];
    mrg_pkg::word_t h2_src  [mrg_pkg::HIST_DEPTH];

    logic           out_valid_reg;
    logic           out_valid_next;
    mrg_pkg::word_t out_value_reg;
    mrg_pkg::word_t out_value_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    mrg_pkg::word_t skid_value_reg;
    mrg_pkg::word_t skid_value_next;

    logic                  launch;
    logic                  use_bypass;
    logic                  clear_hist;
    logic                  add_hist;
    logic                  commit;
    logic                  push;
    logic                  take;
    logic                  done;
    mrg_pkg::step_words_t  words;
    mrg_pkg::step_result_t res;
    mrg_pkg::word_t        z;
    logic [15:0]           half_word;
    logic [32:0]           a1;
    logic [32:0]           a2;
    logic [33:0]           a1m;
    logic [33:0]           a2m;

    mrg_step_pipe u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .words  (words),
        .done   (done),
        .result (res)
    );

    assign commit = (state_reg == mrg_pkg::ST_STEP) && done;
    assign push   = commit && (op_reg == mrg_pkg::OP_GENERATE);

    // combined output, m1 added back when x1 <= x2
    always_comb
    begin
        if (res.x1 <= res.x2)
        begin
            z = 32'(33'(res.x1) + 33'(mrg_pkg::M1) - 33'(res.x2));
        end
        else
        begin
            z = res.x1 - res.x2;
        end
    end

    // output register with skid stage
    assign take = out_valid_reg && result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        skid_valid_next = skid_valid_reg;
        skid_value_next = skid_value_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_value_next  = skid_value_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_value_next = z;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_value_next = z;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.random_value = out_value_reg;

    // shifted histories, used to launch the next step in the commit cycle
    always_comb
    begin
        for (int i = 0; i < mrg_pkg::HIST_DEPTH - 1; i++)
        begin
            h1_sh[i] = h1_reg[i + 1];
            h2_sh[i] = h2_reg[i + 1];
        end
        h1_sh[mrg_pkg::HIST_DEPTH - 1] = res.x1;
        h2_sh[mrg_pkg::HIST_DEPTH - 1] = res.x2;
        for (int i = 0; i < mrg_pkg::HIST_DEPTH; i++)
        begin
            h1_src[i] = use_bypass ? h1_sh[i] : h1_reg[i];
            h2_src[i] = use_bypass ? h2_sh[i] : h2_reg[i];
        end
        words.w13 = h1_src[3];
        words.w11 = h1_src[1];
        words.w10 = h1_src[0];
        words.w24 = h2_src[4];
        words.w22 = h2_src[2];
        words.w20 = h2_src[0];
    end

    // absorb: add half word plus one to the newest words, reduce once
    always_comb
    begin
        half_word = half_reg ? seed_reg[31:16] : seed_reg[15:0];
        a1  = 33'(h1_reg[mrg_pkg::HIST_DEPTH - 1]) + 33'(half_word) + 33'd1;
        a2  = 33'(h2_reg[mrg_pkg::HIST_DEPTH - 1]) + 33'(half_word) + 33'd1;
        a1m = {1'b0, a1} - 34'(mrg_pkg::M1);
        a2m = {1'b0, a2} - 34'(mrg_pkg::M2);
    end

    always_comb
    begin
        for (int i = 0; i < mrg_pkg::HIST_DEPTH; i++)
        begin
            h1_next[i] = h1_reg[i];
            h2_next[i] = h2_reg[i];
        end
        if (clear_hist)
        begin
            for (int i = 0; i < mrg_pkg::HIST_DEPTH; i++)
            begin
                h1_next[i] = mrg_pkg::INIT_WORD;
                h2_next[i] = mrg_pkg::INIT_WORD;
            end
        end
        else if (commit)
        begin
            for (int i = 0; i < mrg_pkg::HIST_DEPTH; i++)
            begin
                h1_next[i] = h1_sh[i];
                h2_next[i] = h2_sh[i];
            end
        end
        else if (add_hist)
        begin
            h1_next[mrg_pkg::HIST_DEPTH - 1] = a1m[33] ? a1[31:0] : a1m[31:0];
            h2_next[mrg_pkg::HIST_DEPTH - 1] = a2m[33] ? a2[31:0] : a2m[31:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        seed_next  = seed_reg;
        half_next  = half_reg;
        steps_next = steps_reg;
        q_pop      = 1'b0;
        launch     = 1'b0;
        use_bypass = 1'b0;
        clear_hist = 1'b0;
        add_hist   = 1'b0;
        case (state_reg)
            mrg_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        mrg_pkg::OP_CLEAR:
                        begin
                            q_pop      = 1'b1;
                            clear_hist = 1'b1;
                        end
                        mrg_pkg::OP_ABSORB:
                        begin
                            q_pop      = 1'b1;
                            seed_next  = q_cmd.seed_word;
                            half_next  = 1'b0;
                            op_next    = mrg_pkg::OP_ABSORB;
                            state_next = mrg_pkg::ST_ADD;
                        end
                        mrg_pkg::OP_GENERATE:
                        begin
                            if (!skid_valid_next)
                            begin
                                q_pop      = 1'b1;
                                launch     = 1'b1;
                                op_next    = mrg_pkg::OP_GENERATE;
                                state_next = mrg_pkg::ST_STEP;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            mrg_pkg::ST_ADD:
            begin
                add_hist   = 1'b1;
                steps_next = STEP_W'(ABSORB_STEPS);
                state_next = mrg_pkg::ST_LAUNCH;
            end
            mrg_pkg::ST_LAUNCH:
            begin
                launch     = 1'b1;
                steps_next = steps_reg - STEP_W'(1);
                state_next = mrg_pkg::ST_STEP;
            end
            mrg_pkg::ST_STEP:
            begin
                if (done)
                begin
                    if (op_reg == mrg_pkg::OP_GENERATE)
                    begin
                        // chain the next generate straight into the freed pipeline
                        if (q_valid && (q_cmd.op == mrg_pkg::OP_GENERATE) &&
                            !skid_valid_next)
                        begin
                            q_pop      = 1'b1;
                            launch     = 1'b1;
                            use_bypass = 1'b1;
                        end
                        else
                        begin
                            state_next = mrg_pkg::ST_IDLE;
                        end
                    end
                    else if (steps_reg != '0)
                    begin
                        launch     = 1'b1;
                        use_bypass = 1'b1;
                        steps_next = steps_reg - STEP_W'(1);
                    end
                    else if (!half_reg)
                    begin
                        half_next  = 1'b1;
                        state_next = mrg_pkg::ST_ADD;
                    end
                    else
                    begin
                        state_next = mrg_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = mrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mrg_pkg::ST_IDLE;
            op_reg         <= mrg_pkg::OP_GENERATE;
            half_reg       <= 1'b0;
            steps_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < mrg_pkg::HIST_DEPTH; i++)
            begin
                h1_reg[i] <= mrg_pkg::INIT_WORD;
                h2_reg[i] <= mrg_pkg::INIT_WORD;
            end
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            half_reg       <= half_next;
            steps_reg      <= steps_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            for (int i = 0; i < mrg_pkg::HIST_DEPTH; i++)
            begin
                h1_reg[i] <= h1_next[i];
                h2_reg[i] <= h2_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg       <= seed_next;
        out_value_reg  <= out_value_next;
        skid_value_reg <= skid_value_next;
    end

endmodule

>>> design/mrg32k5a_random_generator.sv
// generate: passes the queue, the step pipeline stages and the output register
// back-to-back generates: each step waits for the last to leave the 4-stage
//   pipeline, since the newest second-history word feeds the very next step
// absorb: two adds and ten steps of back-end work; clear: resets the histories
// reset: asynchronous, all ten history words to 12345, queue and output empty
// ----------------------------------------------------------------------------
// mrg32k5a_random_generator
// MRG32k5a combined multiple recursive generator: command front end with
// queue, step sequencer and modular arithmetic pipeline behind it.
// ----------------------------------------------------------------------------
module mrg32k5a_random_generator (
    input  logic        clk,
    input  logic        rst_n,
    mrg_cmd_if.sink     cmd,
    mrg_value_if.source result
);

    logic          q_valid;
    logic          q_pop;
    mrg_pkg::cmd_t q_cmd;

    mrg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    mrg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

>>> design/mrg_checker.sv
// ----------------------------------------------------------------------------
// mrg_checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module mrg_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_ready,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [mrg_pkg::WORD_W-1:0] result_random_value
);

    // a stalled result stays offered
    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
    ) else $error("result dropped before transfer");

    a_result_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_random_value)
    ) else $error("stalled result value changed");

    // combined output lies in 1..m1
    a_result_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_random_value != '0) &&
                         (result_random_value <= mrg_pkg::M1)
    ) else $error("result outside 1..m1");

    // queue comes out of reset empty
    a_ready_after_reset: assert property (
        @(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> cmd_ready
    ) else $error("command not ready after reset");

    // no result can finish the step pipeline this soon after reset
    a_no_early_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !$past(rst_n, 4) |-> !result_valid
    ) else $error("result offered too soon after reset");

endmodule

bind mrg32k5a_random_generator mrg_checker u_mrg_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_ready           (cmd.ready),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_random_value (result.random_value)
);
